### src/bbt_pkg.sv
package bbt_pkg;

    localparam int LANES   = 8;
    localparam int LANE_W  = 3;
    localparam int FIELD_W = 8;
    localparam int COUNT_W = 13;
    localparam int CFG_W   = 12;
    localparam int INDEX_W = 12;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd4096;

    localparam logic [1:0] MARK_GOOD     = 2'd0;
    localparam logic [1:0] MARK_BAD      = 2'd1;
    localparam logic [1:0] MARK_RESERVED = 2'd2;
    localparam logic [1:0] MARK_FACTORY  = 2'd3;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] REG_FIELD_WIDTH = 2'd0;
    localparam logic [1:0] REG_RESERVED    = 2'd1;
    localparam logic [1:0] REG_BASE        = 2'd2;
    localparam logic [1:0] REG_ALLOW       = 2'd3;

    // what one lane found for its field
    typedef struct packed {
        logic       write;
        logic       ovf;
        logic       reserved;
        logic       bad;
        logic [1:0] code;
    } lane_res_t;

endpackage

### src/bbt_in_if.sv
interface bbt_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [7:0]  table_byte;
    logic        first;
    logic [11:0] block_index;

    modport source (output valid, output operation, output table_byte, output first,
                    output block_index, input ready);
    modport sink   (input valid, input operation, input table_byte, input first,
                    input block_index, output ready);
endinterface

### src/bbt_out_if.sv
interface bbt_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mark_code;
    logic        is_bad;
    logic [12:0] bad_count;
    logic [12:0] reserved_count;
    logic        overflow;

    modport source (output valid, output mark_code, output is_bad, output bad_count,
                    output reserved_count, output overflow, input ready);
    modport sink   (input valid, input mark_code, input is_bad, input bad_count,
                    input reserved_count, input overflow, output ready);
endinterface

### src/bbt_lane.sv
module bbt_lane (
    input  logic [2:0]                      lane,
    input  logic [1:0]                      width_code,
    input  logic [bbt_pkg::FIELD_W-1:0]     table_byte,
    input  logic [bbt_pkg::FIELD_W-1:0]     reserved_code,
    input  logic                            in_store,
    output bbt_pkg::lane_res_t              res
);
    import bbt_pkg::*;

    logic [3:0]         bits;
    logic [FIELD_W-1:0] msk;
    logic [2:0]         sh;
    logic [FIELD_W-1:0] f;
    logic               active;
    logic               hit;
    logic [1:0]         code;

    always_comb
    begin
        bits   = 4'd1 << width_code;
        msk    = 8'((9'd1 << bits) - 9'd1);
        active = {1'b0, lane} < (4'(LANES) >> width_code);
        sh     = 3'(lane << width_code);
        f      = (table_byte >> sh) & msk;
        hit    = active && (f != msk);
        // reserved match wins over the zero test
        if (reserved_code != '0 && f == reserved_code)
        begin
            code = MARK_RESERVED;
        end
        else if (f == '0)
        begin
            code = MARK_FACTORY;
        end
        else
        begin
            code = MARK_BAD;
        end
        res.write    = hit && in_store;
        res.ovf      = hit && !in_store;
        res.reserved = hit && in_store && (code == MARK_RESERVED);
        res.bad      = hit && in_store && (code != MARK_RESERVED);
        res.code     = code;
    end

endmodule

### src/bbt_bank.sv
module bbt_bank #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [1:0]    rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [1:0]    wr_data
);
    logic [1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### src/bbt_merge.sv
module bbt_merge (
    input  bbt_pkg::lane_res_t               lane_res [bbt_pkg::LANES],
    input  logic [bbt_pkg::COUNT_W-1:0]      bad_total,
    input  logic [bbt_pkg::COUNT_W-1:0]      reserved_total,
    output logic [bbt_pkg::COUNT_W-1:0]      bad_next,
    output logic [bbt_pkg::COUNT_W-1:0]      reserved_next,
    output logic                             overflow
);
    import bbt_pkg::*;

    logic [3:0]       n_bad;
    logic [3:0]       n_res;
    logic [COUNT_W:0] bad_sum;
    logic [COUNT_W:0] res_sum;

    always_comb
    begin
        n_bad    = '0;
        n_res    = '0;
        overflow = 1'b0;
        for (int k = 0; k < LANES; k++)
        begin
            n_bad    = n_bad + 4'(lane_res[k].bad);
            n_res    = n_res + 4'(lane_res[k].reserved);
            overflow = overflow | lane_res[k].ovf;
        end
        bad_sum       = {1'b0, bad_total} + (COUNT_W+1)'(n_bad);
        res_sum       = {1'b0, reserved_total} + (COUNT_W+1)'(n_res);
        // counts stop at COUNT_MAX (4096)
        bad_next      = (bad_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : bad_sum[COUNT_W-1:0];
        reserved_next = (res_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : res_sum[COUNT_W-1:0];
    end

endmodule

### src/bad_block_table_decode_lookup.sv
// an accepted word waits in S_WRITE until the output register is free to take its result
// a new word waits until the last one leaves S_WRITE, for the read-modify-write of the mark banks
// the input takes a new word while a finished result still waits at the output register
// reset: registers return to their defaults, then a clearing pass zeroes the mark banks,
// one row of eight marks a cycle over all ceil(BLOCKS/8) rows, with no word accepted meanwhile
module bad_block_table_decode_lookup #(
    parameter int BLOCKS = 4096
) (
    input  logic                       clk,
    input  logic                       rst_n,
    bbt_in_if.sink                     in_ch,
    bbt_out_if.source                  out_ch,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [bbt_pkg::CFG_W-1:0]  cfg_data
);
    import bbt_pkg::*;

    // marks are spread over eight banks by block index modulo eight, so the
    // eight consecutive blocks of one table byte always land in distinct banks
    localparam int DEPTH = (BLOCKS + LANES - 1) / LANES;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(BLOCKS + 1);
    localparam int SW    = (CW + 1 > INDEX_W + 1) ? CW + 1 : INDEX_W + 1;
    localparam logic [SW-1:0] BLK = SW'(BLOCKS);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_WRITE
    } state_t;

    // configuration registers
    logic [1:0]         field_width_reg;
    logic [FIELD_W-1:0] reserved_code_reg;
    logic [INDEX_W-1:0] base_block_reg;
    logic               allow_reserved_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_width_reg    <= 2'd1;
            reserved_code_reg  <= '0;
            base_block_reg     <= '0;
            allow_reserved_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FIELD_WIDTH: field_width_reg    <= cfg_data[1:0];
                REG_RESERVED:    reserved_code_reg  <= cfg_data[FIELD_W-1:0];
                REG_BASE:        base_block_reg     <= cfg_data[INDEX_W-1:0];
                REG_ALLOW:       allow_reserved_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    state_t              state_reg;
    logic [AW-1:0]       clr_addr_reg;
    logic [CW-1:0]       counter_reg;
    logic [COUNT_W-1:0]  bad_total_reg;
    logic [COUNT_W-1:0]  reserved_total_reg;
    logic [SW-1:0]       start_reg;
    logic                op_reg;
    logic [FIELD_W-1:0]  byte_reg;
    logic [AW-1:0]       addr_reg [LANES];
    logic                out_valid_reg;
    logic [1:0]          mark_reg;
    logic                is_bad_reg;
    logic [COUNT_W-1:0]  bad_count_reg;
    logic [COUNT_W-1:0]  reserved_count_reg;
    logic                overflow_reg;

    logic                accept;
    logic                go;
    logic [SW-1:0]       base_clip;
    logic [SW-1:0]       start_c;
    logic                rd_en   [LANES];
    logic [AW-1:0]       rd_addr [LANES];
    logic [1:0]          rd_data [LANES];
    logic                wr_en   [LANES];
    logic [AW-1:0]       wr_addr [LANES];
    logic [1:0]          wr_data [LANES];
    lane_res_t           lane_res [LANES];
    logic [COUNT_W-1:0]  bad_next;
    logic [COUNT_W-1:0]  reserved_next;
    logic                load_ovf;
    logic [SW-1:0]       end_sum;
    logic [CW-1:0]       counter_next;
    logic                q_in_range;
    logic [1:0]          q_mark;
    logic                q_bad;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    // result can move into the output register
    assign go          = (state_reg == S_WRITE) && (!out_valid_reg || out_ch.ready);

    // first block of this word: query index, restarted base, or running counter
    always_comb
    begin
        base_clip = (SW'(base_block_reg) < BLK) ? SW'(base_block_reg) : BLK;
        if (in_ch.operation == OP_QUERY)
        begin
            start_c = SW'(in_ch.block_index);
        end
        else if (in_ch.first)
        begin
            start_c = base_clip;
        end
        else
        begin
            start_c = SW'(counter_reg);
        end
    end

    // read side: each bank reads the row holding the block that falls into it
    always_comb
    begin
        logic [LANE_W-1:0] off;
        logic [SW-1:0]     blk;
        logic [SW-1:0]     row;
        for (int b = 0; b < LANES; b++)
        begin
            off        = LANE_W'(b) - start_c[LANE_W-1:0];
            blk        = start_c + SW'(off);
            row        = blk >> LANE_W;
            rd_en[b]   = accept && (row < SW'(DEPTH));
            rd_addr[b] = row[AW-1:0];
        end
    end

    // decode lanes, one per field position of the byte
    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        logic in_store;
        assign in_store = (start_reg + SW'(k)) < BLK;
        bbt_lane u_lane (
            .lane          (LANE_W'(k)),
            .width_code    (field_width_reg),
            .table_byte    (byte_reg),
            .reserved_code (reserved_code_reg),
            .in_store      (in_store),
            .res           (lane_res[k])
        );
    end

    bbt_merge u_merge (
        .lane_res       (lane_res),
        .bad_total      (bad_total_reg),
        .reserved_total (reserved_total_reg),
        .bad_next       (bad_next),
        .reserved_next  (reserved_next),
        .overflow       (load_ovf)
    );

    // write side: clearing zeroes rows; else each bank ORs in the mark of its block's lane
    always_comb
    begin
        logic [LANE_W-1:0] k;
        for (int b = 0; b < LANES; b++)
        begin
            k = LANE_W'(b) - start_reg[LANE_W-1:0];
            if (state_reg == S_CLEAR)
            begin
                wr_en[b]   = 1'b1;
                wr_addr[b] = clr_addr_reg;
                wr_data[b] = MARK_GOOD;
            end
            else
            begin
                wr_en[b]   = go && (op_reg == OP_LOAD) && lane_res[k].write;
                wr_addr[b] = addr_reg[b];
                wr_data[b] = rd_data[b] | lane_res[k].code;
            end
        end
    end

    for (genvar b = 0; b < LANES; b++)
    begin : g_bank
        bbt_bank #(
            .DEPTH (DEPTH),
            .AW    (AW)
        ) u_bank (
            .clk     (clk),
            .rd_en   (rd_en[b]),
            .rd_addr (rd_addr[b]),
            .rd_data (rd_data[b]),
            .wr_en   (wr_en[b]),
            .wr_addr (wr_addr[b]),
            .wr_data (wr_data[b])
        );
    end

    // counter stops at the store size
    always_comb
    begin
        end_sum      = start_reg + (SW'(LANES) >> field_width_reg);
        counter_next = (end_sum < BLK) ? end_sum[CW-1:0] : BLK[CW-1:0];
    end

    // query verdict
    always_comb
    begin
        q_in_range = start_reg < BLK;
        q_mark     = q_in_range ? rd_data[start_reg[LANE_W-1:0]] : MARK_GOOD;
        if (!q_in_range)
        begin
            q_bad = 1'b1;
        end
        else
        begin
            unique case (q_mark)
                MARK_GOOD:     q_bad = 1'b0;
                MARK_RESERVED: q_bad = !allow_reserved_reg;
                default:       q_bad = 1'b1;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_CLEAR;
            clr_addr_reg       <= '0;
            counter_reg        <= '0;
            bad_total_reg      <= '0;
            reserved_total_reg <= '0;
            start_reg          <= '0;
            op_reg             <= OP_LOAD;
            byte_reg           <= '0;
            for (int b = 0; b < LANES; b++)
            begin
                addr_reg[b] <= '0;
            end
            out_valid_reg      <= 1'b0;
            mark_reg           <= MARK_GOOD;
            is_bad_reg         <= 1'b0;
            bad_count_reg      <= '0;
            reserved_count_reg <= '0;
            overflow_reg       <= 1'b0;
        end
        else
        begin
            // a result leaving with no new one behind it empties the register
            if (out_valid_reg && out_ch.ready && !go)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                    if (clr_addr_reg == AW'(DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        start_reg <= start_c;
                        op_reg    <= in_ch.operation;
                        byte_reg  <= in_ch.table_byte;
                        for (int b = 0; b < LANES; b++)
                        begin
                            addr_reg[b] <= rd_addr[b];
                        end
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    if (go)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                        if (op_reg == OP_LOAD)
                        begin
                            counter_reg        <= counter_next;
                            bad_total_reg      <= bad_next;
                            reserved_total_reg <= reserved_next;
                            mark_reg           <= MARK_GOOD;
                            is_bad_reg         <= 1'b0;
                            bad_count_reg      <= bad_next;
                            reserved_count_reg <= reserved_next;
                            overflow_reg       <= load_ovf;
                        end
                        else
                        begin
                            mark_reg           <= q_mark;
                            is_bad_reg         <= q_bad;
                            bad_count_reg      <= bad_total_reg;
                            reserved_count_reg <= reserved_total_reg;
                            overflow_reg       <= 1'b0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.mark_code      = mark_reg;
    assign out_ch.is_bad         = is_bad_reg;
    assign out_ch.bad_count      = bad_count_reg;
    assign out_ch.reserved_count = reserved_count_reg;
    assign out_ch.overflow       = overflow_reg;

endmodule
